/* src/layer_cell_resolve_with_shadow_top_macros.svh */
// Assertion helpers used by lcr_pipe.
`ifndef LAYER_CELL_RESOLVE_WITH_SHADOW_TOP_MACROS_SVH
`define LAYER_CELL_RESOLVE_WITH_SHADOW_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define LCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* src/lcr_pkg.sv */
package lcr_pkg;
  localparam int unsigned MaxLayersDefault = 8;
  localparam int unsigned IdxW = 5;
  localparam int unsigned LimW = 6;

  typedef enum logic [1:0] {
    MODE_RECT    = 2'd0,
    MODE_CLIP    = 2'd1,
    MODE_SCLIP   = 2'd2,
    MODE_RESOLVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_SHADOW_DX = 2'd0,
    REG_SHADOW_DY = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } box_t;

  // Wide signed coordinate, room for edge plus extent plus offset
  typedef logic signed [19:0] crd_t;

  function automatic crd_t sx16(logic signed [15:0] v);
    return crd_t'(v);
  endfunction

  function automatic crd_t ux15(logic [14:0] v);
    return crd_t'({5'd0, v});
  endfunction

  function automatic logic holds(crd_t px, crd_t py, crd_t x, crd_t y, crd_t w, crd_t h);
    return (px >= x) && (px < x + w) && (py >= y) && (py < y + h);
  endfunction
endpackage

/* src/lcr_table.sv */
module lcr_table #(
  parameter int unsigned MaxLayers = lcr_pkg::MaxLayersDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  lcr_pkg::mode_e        wr_mode_i,
  input  logic [2:0]            wr_slot_i,
  input  lcr_pkg::box_t         wr_box_i,
  input  logic                  wr_flag_i,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  output lcr_pkg::box_t         frame_o  [MaxLayers],
  output lcr_pkg::box_t         clip_o   [MaxLayers],
  output lcr_pkg::box_t         sclip_o  [MaxLayers],
  output logic [MaxLayers-1:0]  cast_o,
  output logic [MaxLayers-1:0]  clip_on_o,
  output logic [MaxLayers-1:0]  sclip_on_o,
  output logic signed [7:0]     dx_o,
  output logic signed [7:0]     dy_o
);
  import lcr_pkg::*;

  box_t                 frame_q [MaxLayers];
  box_t                 clip_q  [MaxLayers];
  box_t                 sclip_q [MaxLayers];
  logic [MaxLayers-1:0] cast_q, clip_on_q, sclip_on_q;
  logic signed [7:0]    dx_q, dy_q;

  // Load one table entry per write transaction; slots past the table drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLayers; i++) begin
        frame_q[i] <= '0;
        clip_q[i]  <= '0;
        sclip_q[i] <= '0;
      end
      cast_q     <= '0;
      clip_on_q  <= '0;
      sclip_on_q <= '0;
    end else if (wr_en_i) begin
      for (int i = 0; i < MaxLayers; i++) begin
        if (32'(wr_slot_i) == i) begin
          case (wr_mode_i)
            MODE_RECT: begin
              frame_q[i] <= wr_box_i;
              cast_q[i]  <= wr_flag_i;
            end
            MODE_CLIP: begin
              clip_q[i]    <= wr_box_i;
              clip_on_q[i] <= wr_flag_i;
            end
            MODE_SCLIP: begin
              sclip_q[i]    <= wr_box_i;
              sclip_on_q[i] <= wr_flag_i;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Shadow offset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_q <= 8'sd1;
      dy_q <= 8'sd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SHADOW_DX: dx_q <= cfg_data_i;
        REG_SHADOW_DY: dy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign frame_o    = frame_q;
  assign clip_o     = clip_q;
  assign sclip_o    = sclip_q;
  assign cast_o     = cast_q;
  assign clip_on_o  = clip_on_q;
  assign sclip_on_o = sclip_on_q;
  assign dx_o       = dx_q;
  assign dy_o       = dy_q;
endmodule

/* src/lcr_pipe.sv */
`include "layer_cell_resolve_with_shadow_top_macros.svh"
module lcr_pipe #(
  parameter int unsigned MaxLayers = lcr_pkg::MaxLayersDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  q_valid_i,
  input  logic signed [15:0]    px_i,
  input  logic signed [15:0]    py_i,
  input  logic [3:0]            limit_i,
  input  lcr_pkg::box_t         frame_i  [MaxLayers],
  input  lcr_pkg::box_t         clip_i   [MaxLayers],
  input  lcr_pkg::box_t         sclip_i  [MaxLayers],
  input  logic [MaxLayers-1:0]  cast_i,
  input  logic [MaxLayers-1:0]  clip_on_i,
  input  logic [MaxLayers-1:0]  sclip_on_i,
  input  logic signed [7:0]     dx_i,
  input  logic signed [7:0]     dy_i,
  output logic                  valid_o,
  output logic                  bg_o,
  output logic [2:0]            hit_o,
  output logic signed [16:0]    lx_o,
  output logic signed [16:0]    ly_o,
  output logic                  shad_o
);
  import lcr_pkg::*;

  localparam logic [LimW-1:0] LimMax = LimW'(MaxLayers);

  // Stage 1: effective rectangles, layer count mask
  logic                 v1_q;
  crd_t                 px1_q, py1_q;
  crd_t                 ex_q [MaxLayers], ey_q [MaxLayers];
  crd_t                 ew_q [MaxLayers], eh_q [MaxLayers];
  logic signed [15:0]   fx1_q [MaxLayers], fy1_q [MaxLayers];
  box_t                 sc1_q [MaxLayers];
  logic [MaxLayers-1:0] cnt1_q, cast1_q, scon1_q;
  crd_t                 ex_d [MaxLayers], ey_d [MaxLayers];
  crd_t                 ew_d [MaxLayers], eh_d [MaxLayers];
  logic [MaxLayers-1:0] cnt_d;
  logic [LimW-1:0]      lim;

  always_comb begin
    crd_t ax, ay, ar, ab, cx, cy, cr, cb, rx, ry, rr, rb;
    lim = ({2'b00, limit_i} > LimMax) ? LimMax : {2'b00, limit_i};
    for (int i = 0; i < MaxLayers; i++) begin
      cnt_d[i] = (LimW'(i) < lim);
      ax = sx16(frame_i[i].x);
      ay = sx16(frame_i[i].y);
      ar = ax + ux15(frame_i[i].w);
      ab = ay + ux15(frame_i[i].h);
      cx = sx16(clip_i[i].x);
      cy = sx16(clip_i[i].y);
      cr = cx + ux15(clip_i[i].w);
      cb = cy + ux15(clip_i[i].h);
      rx = (ax > cx) ? ax : cx;
      ry = (ay > cy) ? ay : cy;
      rr = (ar < cr) ? ar : cr;
      rb = (ab < cb) ? ab : cb;
      if (clip_on_i[i]) begin
        ex_d[i] = rx;
        ey_d[i] = ry;
        ew_d[i] = (rr - rx > 0) ? rr - rx : '0;
        eh_d[i] = (rb - ry > 0) ? rb - ry : '0;
      end else begin
        ex_d[i] = ax;
        ey_d[i] = ay;
        ew_d[i] = ux15(frame_i[i].w);
        eh_d[i] = ux15(frame_i[i].h);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv_i) v1_q <= q_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px1_q   <= sx16(px_i);
      py1_q   <= sx16(py_i);
      cnt1_q  <= cnt_d;
      cast1_q <= cast_i;
      scon1_q <= sclip_on_i;
      for (int i = 0; i < MaxLayers; i++) begin
        ex_q[i]  <= ex_d[i];
        ey_q[i]  <= ey_d[i];
        ew_q[i]  <= ew_d[i];
        eh_q[i]  <= eh_d[i];
        fx1_q[i] <= frame_i[i].x;
        fy1_q[i] <= frame_i[i].y;
        sc1_q[i] <= sclip_i[i];
      end
    end
  end

  // Stage 2: per-layer hit and shadow tests
  logic                 v2_q;
  crd_t                 px2_q, py2_q;
  logic signed [15:0]   fx2_q [MaxLayers], fy2_q [MaxLayers];
  logic [MaxLayers-1:0] hit2_q, sh2_q, hit_d, sh_d;

  always_comb begin
    crd_t dx, dy, rh;
    logic sok;
    dx = crd_t'(dx_i);
    dy = crd_t'(dy_i);
    for (int i = 0; i < MaxLayers; i++) begin
      rh  = (eh_q[i] - dy < 0) ? '0 : eh_q[i] - dy;
      sok = !scon1_q[i] || holds(px1_q, py1_q, sx16(sc1_q[i].x), sx16(sc1_q[i].y),
                                 ux15(sc1_q[i].w), ux15(sc1_q[i].h));
      hit_d[i] = cnt1_q[i] && holds(px1_q, py1_q, ex_q[i], ey_q[i], ew_q[i], eh_q[i]);
      sh_d[i]  = cnt1_q[i] && cast1_q[i] && sok &&
                 (holds(px1_q, py1_q, ex_q[i] + ew_q[i], ey_q[i] + dy, dx, rh) ||
                  holds(px1_q, py1_q, ex_q[i] + dx, ey_q[i] + eh_q[i], ew_q[i], dy));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv_i) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      hit2_q <= hit_d;
      sh2_q  <= sh_d;
      fx2_q  <= fx1_q;
      fy2_q  <= fy1_q;
    end
  end

  // Stage 3: pick the topmost hit, fold shadows above it
  logic                 vo_q, bg_q, shad_q;
  logic [2:0]           hit_q;
  logic signed [16:0]   lx_q, ly_q;
  logic                 found, acc;
  logic [IdxW-1:0]      idx;
  logic signed [16:0]   lx_d, ly_d;

  always_comb begin
    found = 1'b0;
    acc   = 1'b0;
    idx   = '0;
    lx_d  = px2_q[16:0];
    ly_d  = py2_q[16:0];
    for (int i = 0; i < MaxLayers; i++) begin
      if (hit2_q[i]) begin
        found = 1'b1;
        acc   = 1'b0;
        idx   = IdxW'(i);
        lx_d  = px2_q[16:0] - 17'(fx2_q[i]);
        ly_d  = py2_q[16:0] - 17'(fy2_q[i]);
      end else if (sh2_q[i]) begin
        acc = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (adv_i) vo_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bg_q   <= !found;
      hit_q  <= idx[2:0];
      lx_q   <= lx_d;
      ly_q   <= ly_d;
      shad_q <= acc;
    end
  end

  assign valid_o = vo_q;
  assign bg_o    = bg_q;
  assign hit_o   = hit_q;
  assign lx_o    = lx_q;
  assign ly_o    = ly_q;
  assign shad_o  = shad_q;

  `LCR_ASSERT(a_bg_idx, clk_i, rst_ni, vo_q && bg_q |-> hit_q == 3'd0, "background with layer index")
  `LCR_ASSERT_NEXT(a_flow, clk_i, rst_ni, v2_q && adv_i, vo_q, "result lost between stages")
  `LCR_ASSERT_NEXT(a_hold, clk_i, rst_ni, !adv_i, $stable(v1_q) && $stable(v2_q) && $stable(vo_q), "stage moved while held")
endmodule

/* src/layer_cell_resolve_with_shadow_top.sv */
// Layered hit test with drop-shadow coverage.
// Input channel (in_valid_i / in_stall_o): mode 0..2 items write one entry
// of the layer table (rect with shadow flag, content clip, shadow clip) and
// give no result; mode 3 items resolve a point against the lowest
// layer_limit layers, topmost first.
// Output channel (out_valid_o / out_stall_i): one result per resolve item,
// in order: winning layer or background, point relative to the winner,
// and whether a shadow from a layer above the winner covers the point.
// Config channel (cfg_valid_i / cfg_ready_o, always ready): index 0 sets
// shadow_dx, index 1 sets shadow_dy; write only while idle.
// Three register stages: out_valid_o rises once an accepted item has passed
// all three; one item per cycle while out_stall_i does not hold them.
// The three stages (effective rect, per-layer tests, priority pick) move
// together, so a stall on the output holds every stage and raises
// in_stall_o in the same cycle. Writes take effect for the next item.
// Reset empties the pipeline, clears the table and sets both offsets to 1.
module layer_cell_resolve_with_shadow_top #(
  parameter int unsigned MAX_LAYERS = lcr_pkg::MaxLayersDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         layer_slot_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic [14:0]        extent_w_i,
  input  logic [14:0]        extent_h_i,
  input  logic               flag_i,
  input  logic [3:0]         layer_limit_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               from_background_o,
  output logic [2:0]         hit_layer_o,
  output logic signed [16:0] local_x_o,
  output logic signed [16:0] local_y_o,
  output logic               shadowed_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import lcr_pkg::*;

  box_t                  frame [MAX_LAYERS], clip [MAX_LAYERS], sclip [MAX_LAYERS];
  logic [MAX_LAYERS-1:0] cast, clip_on, sclip_on;
  logic signed [7:0]     dx, dy;
  logic                  adv, acc_in, wr_en, q_valid;
  mode_e                 mode;
  box_t                  wr_box;

  // Whole pipeline advances unless a result waits on a stalled receiver
  assign adv         = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !adv;
  assign acc_in      = in_valid_i && adv;
  assign mode        = mode_e'(mode_i);
  assign wr_en       = acc_in && (mode != MODE_RESOLVE);
  assign q_valid     = in_valid_i && (mode == MODE_RESOLVE);
  assign cfg_ready_o = 1'b1;
  assign wr_box      = '{x: coord_x_i, y: coord_y_i, w: extent_w_i, h: extent_h_i};

  lcr_table #(.MaxLayers(MAX_LAYERS)) u_table (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_mode_i(mode), .wr_slot_i(layer_slot_i),
    .wr_box_i(wr_box), .wr_flag_i(flag_i),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .frame_o(frame), .clip_o(clip), .sclip_o(sclip),
    .cast_o(cast), .clip_on_o(clip_on), .sclip_on_o(sclip_on),
    .dx_o(dx), .dy_o(dy)
  );

  lcr_pipe #(.MaxLayers(MAX_LAYERS)) u_pipe (
    .clk_i, .rst_ni,
    .adv_i(adv), .q_valid_i(q_valid),
    .px_i(coord_x_i), .py_i(coord_y_i), .limit_i(layer_limit_i),
    .frame_i(frame), .clip_i(clip), .sclip_i(sclip),
    .cast_i(cast), .clip_on_i(clip_on), .sclip_on_i(sclip_on),
    .dx_i(dx), .dy_i(dy),
    .valid_o(out_valid_o), .bg_o(from_background_o), .hit_o(hit_layer_o),
    .lx_o(local_x_o), .ly_o(local_y_o), .shad_o(shadowed_o)
  );
endmodule
